// ===== rtl/rtufcc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the
// RTU frame address and CRC check unit. No dependencies.
package rtufcc_pkg;

  localparam int MAX_FRAME = 256;
  localparam int LEN_W     = $clog2(MAX_FRAME + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0]       BROADCAST_ADDR = 8'hFF;
  localparam logic [7:0]       SLAVE_ADDR_RST = 8'h01;
  localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY       = 16'hA001;
  localparam logic [LEN_W-1:0] MIN_FRAME      = LEN_W'(4);
  localparam logic [LEN_W-1:0] MAX_LEN        = LEN_W'(MAX_FRAME);

  // register index, taken from the word address (paddr[2])
  localparam logic REG_SLAVE_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    STAT_ACCEPTED      = 2'd0,
    STAT_SHORT         = 2'd1,
    STAT_ADDR_MISMATCH = 2'd2,
    STAT_CRC_MISMATCH  = 2'd3
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    logic             valid;
    status_t          frame_status;
    logic             is_broadcast;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]      computed_crc;
  } result_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/rtufcc_if.sv =====
// Valid/ready channel interfaces for received bytes and frame verdicts.
// Depends on rtufcc_pkg.
interface rtufcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, rx_byte, end_of_frame, input ready);
  modport sink   (input valid, rx_byte, end_of_frame, output ready);
endinterface

interface rtufcc_out_if;
  logic                          valid;
  logic                          ready;
  rtufcc_pkg::status_t           frame_status;
  logic                          is_broadcast;
  logic [rtufcc_pkg::LEN_W-1:0]  frame_length;
  logic [15:0]                   computed_crc;

  modport source (output valid, frame_status, is_broadcast, frame_length, computed_crc,
                  input ready);
  modport sink   (input valid, frame_status, is_broadcast, frame_length, computed_crc,
                  output ready);
endinterface

// ===== rtl/rtufcc_apb_regs.sv =====
// APB configuration register: slave address.
// Depends on rtufcc_pkg.
module rtufcc_apb_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtufcc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rtufcc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rtufcc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  output logic [7:0]                          slave_addr
);

  logic [7:0] slave_addr_r;
  logic [7:0] slave_addr_nxt;
  logic       hit;

  assign pready = 1'b1;
  assign hit    = paddr[2] == rtufcc_pkg::REG_SLAVE_ADDRESS;

  always_comb begin
    slave_addr_nxt = slave_addr_r;
    if (psel && penable && pwrite && pready && hit) begin
      slave_addr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= rtufcc_pkg::SLAVE_ADDR_RST;
    end else begin
      slave_addr_r <= slave_addr_nxt;
    end
  end

  assign prdata     = hit ? {{(rtufcc_pkg::APB_DATA_W-8){1'b0}}, slave_addr_r}
                          : '0;
  assign slave_addr = slave_addr_r;

endmodule

// ===== rtl/rtufcc_in_stage.sv =====
// Input register: holds one accepted byte until the frame core takes it.
// Depends on rtufcc_pkg and rtufcc_in_if.
module rtufcc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  rtufcc_in_if.sink          in_if,
  output rtufcc_pkg::item_t  item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       eof_r;
  logic       take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_if.rx_byte;
      eof_r  <= in_if.end_of_frame;
    end
  end

  assign item = '{valid: valid_r, rx_byte: byte_r, end_of_frame: eof_r};

endmodule

// ===== rtl/rtufcc_frame_core.sv =====
// Frame state (CRC, trailing-byte delay line, count, address) and verdict.
// Depends on rtufcc_pkg.
module rtufcc_frame_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  rtufcc_pkg::item_t    item,
  input  logic [7:0]           slave_addr,
  output rtufcc_pkg::result_t  res
);

  localparam int LW = rtufcc_pkg::LEN_W;

  logic [15:0]   crc_r,   crc_nxt;
  logic [7:0]    older_r, older_nxt;
  logic [7:0]    newer_r, newer_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [7:0]    addr_r,  addr_nxt;

  logic [15:0]   crc_upd;
  logic [LW-1:0] count_upd;
  logic [7:0]    addr_upd;
  logic [15:0]   swapped;
  logic [15:0]   received;
  logic          bcast;
  rtufcc_pkg::status_t status;

  always_comb begin
    // older byte enters the CRC once two bytes sit behind it
    crc_upd   = (count_r >= LW'(2)) ? rtufcc_pkg::crc_feed(crc_r, older_r) : crc_r;
    addr_upd  = (count_r == '0) ? item.rx_byte : addr_r;
    count_upd = (count_r < rtufcc_pkg::MAX_LEN) ? count_r + LW'(1) : count_r;

    swapped  = {crc_upd[7:0], crc_upd[15:8]};
    received = {newer_r, item.rx_byte};
    bcast    = addr_upd == rtufcc_pkg::BROADCAST_ADDR;

    priority if (count_upd < rtufcc_pkg::MIN_FRAME) begin
      status = rtufcc_pkg::STAT_SHORT;
    end else if (!bcast && addr_upd != slave_addr) begin
      status = rtufcc_pkg::STAT_ADDR_MISMATCH;
    end else if (received != swapped) begin
      status = rtufcc_pkg::STAT_CRC_MISMATCH;
    end else begin
      status = rtufcc_pkg::STAT_ACCEPTED;
    end

    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    if (advance) begin
      addr_nxt = addr_upd;
      if (item.end_of_frame) begin
        crc_nxt   = rtufcc_pkg::CRC_INIT;
        older_nxt = '0;
        newer_nxt = '0;
        count_nxt = '0;
      end else begin
        crc_nxt   = crc_upd;
        older_nxt = newer_r;
        newer_nxt = item.rx_byte;
        count_nxt = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= rtufcc_pkg::CRC_INIT;
      older_r <= '0;
      newer_r <= '0;
      count_r <= '0;
      addr_r  <= '0;
    end else begin
      crc_r   <= crc_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign res = '{valid:        advance && item.end_of_frame,
                 frame_status: status,
                 is_broadcast: bcast,
                 frame_length: count_upd,
                 computed_crc: swapped};

endmodule

// ===== rtl/rtufcc_out_stage.sv =====
// Result register driving the verdict channel.
// Depends on rtufcc_pkg and rtufcc_out_if.
module rtufcc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtufcc_pkg::result_t  res,
  output logic                 slot_free,
  rtufcc_out_if.source         out_if
);

  logic                valid_r;
  logic                valid_nxt;
  rtufcc_pkg::result_t data_r;

  assign slot_free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res;
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.frame_status = data_r.frame_status;
  assign out_if.is_broadcast = data_r.is_broadcast;
  assign out_if.frame_length = data_r.frame_length;
  assign out_if.computed_crc = data_r.computed_crc;

endmodule

// ===== rtl/rtu_frame_address_crc_check_unit.sv =====
// Top level of the RTU frame address and CRC check unit.
// Depends on rtufcc_pkg, rtufcc_if and the rtufcc_* submodules.
//
//  channel  | dir | transaction                          | handshake
//  ---------+-----+--------------------------------------+--------------
//  in_if    | in  | one frame byte, end_of_frame marker  | valid/ready
//  out_if   | out | verdict, broadcast flag, length, CRC | valid/ready
//  APB      | in  | slave_address at byte address 0      | psel/penable
//
// An accepted byte is held in the input register; from there the CRC byte
// update and verdict logic load the result register, so a verdict passes
// through both registers after its end-of-frame byte is accepted. One byte
// is accepted every cycle while no end-of-frame byte is stalled. The 8-step
// CRC byte update feeding the CRC compare sets the cycle time.
// A byte without end_of_frame never waits on out_if; an end-of-frame byte
// stalls only while the result register is full and not taken.
// rst_n is synchronous: frame state clears, slave_address returns to 1.
module rtu_frame_address_crc_check_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  rtufcc_in_if.sink                          in_if,
  rtufcc_out_if.source                       out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtufcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rtufcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rtufcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready
);

  rtufcc_pkg::item_t   item;
  rtufcc_pkg::result_t res;
  logic                slot_free;
  logic                advance;
  logic [7:0]          slave_addr;

  // a held byte moves on unless it ends a frame and the result slot is busy
  assign advance = item.valid && (!item.end_of_frame || slot_free);

  rtufcc_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slave_addr (slave_addr)
  );

  rtufcc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_if   (in_if),
    .item    (item)
  );

  // CRC, delay line, byte count and address; verdict on the end-of-frame byte
  rtufcc_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item       (item),
    .slave_addr (slave_addr),
    .res        (res)
  );

  rtufcc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .slot_free (slot_free),
    .out_if    (out_if)
  );

`ifndef SYNTHESIS
  // an end-of-frame byte leaving the input register always yields a verdict
  a_eof_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.end_of_frame |=> out_if.valid)
    else $error("end-of-frame transaction produced no verdict");

  // a new verdict appears only after an end-of-frame byte moved on
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(advance && item.end_of_frame))
    else $error("verdict without end-of-frame byte");

  // short status exactly when fewer than four bytes were counted
  a_short_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      ((out_if.frame_status == rtufcc_pkg::STAT_SHORT) ==
       (out_if.frame_length < rtufcc_pkg::MIN_FRAME)))
    else $error("short status disagrees with frame length");
`endif

endmodule
